[src/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and constants for the button qualifier
// Holds the register indexes, event and state codes, and the item and
// configuration structures used across the block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_DEBOUNCE_MS    = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS_MS  = 3'd1;
  localparam logic [2:0] CFG_REPEAT_MS      = 3'd2;
  localparam logic [2:0] CFG_INTERRUPT_MODE = 3'd3;
  localparam logic [2:0] CFG_PIN_MASK       = 3'd4;
  localparam logic [2:0] CFG_RELEASE_STEP   = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_DEBOUNCE_MS   = 32'd20;
  localparam logic [31:0] RST_LONG_PRESS_MS = 32'd1000;
  localparam logic [31:0] RST_REPEAT_MS     = 32'd200;
  localparam logic [15:0] RST_PIN_MASK      = 16'd1;

  // Item action codes
  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_IRQ  = 1'b1;

  // Reported state codes
  localparam logic [2:0] SC_IDLE     = 3'd0;
  localparam logic [2:0] SC_DEBOUNCE = 3'd1;
  localparam logic [2:0] SC_PRESSED  = 3'd2;
  localparam logic [2:0] SC_REPEAT   = 3'd3;
  localparam logic [2:0] SC_RELEASE  = 3'd4;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  // Internal one-hot state
  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DEBOUNCE = 5'b00010,
    ST_PRESSED  = 5'b00100,
    ST_REPEAT   = 5'b01000,
    ST_RELEASE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [31:0] debounce_ms;
    logic [31:0] long_press_ms;
    logic [31:0] repeat_ms;
    logic        interrupt_mode;
    logic [15:0] button_pin_mask;
    logic        release_step_enable;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        pin_pressed;
    logic [15:0] irq_pin_mask;
    logic [31:0] now_ms;
  } item_t;

  // One-hot state to reported code
  function automatic logic [2:0] state_code(state_t s);
    logic [2:0] c;
    case (s)
      ST_IDLE:     c = SC_IDLE;
      ST_DEBOUNCE: c = SC_DEBOUNCE;
      ST_PRESSED:  c = SC_PRESSED;
      ST_REPEAT:   c = SC_REPEAT;
      ST_RELEASE:  c = SC_RELEASE;
      default:     c = SC_IDLE;
    endcase
    return c;
  endfunction

endpackage

[src/bdlp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bdlp_cfg_regs: configuration register file
// Six write-only registers, masked to their widths; unknown indexes ignored.
// ----------------------------------------------------------------------------
module bdlp_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output bdlp_pkg::cfg_t      cfg
);

  bdlp_pkg::cfg_t regs;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms         <= bdlp_pkg::RST_DEBOUNCE_MS;
      regs.long_press_ms       <= bdlp_pkg::RST_LONG_PRESS_MS;
      regs.repeat_ms           <= bdlp_pkg::RST_REPEAT_MS;
      regs.interrupt_mode      <= 1'b0;
      regs.button_pin_mask     <= bdlp_pkg::RST_PIN_MASK;
      regs.release_step_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::CFG_DEBOUNCE_MS:    regs.debounce_ms         <= cfg_data;
        bdlp_pkg::CFG_LONG_PRESS_MS:  regs.long_press_ms       <= cfg_data;
        bdlp_pkg::CFG_REPEAT_MS:      regs.repeat_ms           <= cfg_data;
        bdlp_pkg::CFG_INTERRUPT_MODE: regs.interrupt_mode      <= cfg_data[0];
        bdlp_pkg::CFG_PIN_MASK:       regs.button_pin_mask     <= cfg_data[15:0];
        bdlp_pkg::CFG_RELEASE_STEP:   regs.release_step_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[src/bdlp_fsm.sv]
// ----------------------------------------------------------------------------
// bdlp_fsm: qualifier state machine
// Holds state, time stamp and latched interrupt flag; computes the event and
// next state for the item in the input register and commits on fire.
// ----------------------------------------------------------------------------
module bdlp_fsm (
  input  logic                clk,
  input  logic                rst,
  input  bdlp_pkg::cfg_t      cfg,
  input  logic                fire,
  input  bdlp_pkg::item_t     item,
  output bdlp_pkg::event_t    event_code,
  output logic [2:0]          state_out
);

  bdlp_pkg::state_t state, state_next;
  logic [31:0]      last_stamp, last_stamp_next;
  logic             irq_latched, irq_latched_next;

  logic [31:0] elapsed;
  logic [31:0] limit;
  logic        expired;

  // Timeout: wrapping difference strictly above the threshold for this state
  assign elapsed = item.now_ms - last_stamp;

  always_comb begin
    case (state)
      bdlp_pkg::ST_DEBOUNCE: limit = cfg.debounce_ms;
      bdlp_pkg::ST_PRESSED:  limit = cfg.long_press_ms;
      default:               limit = cfg.repeat_ms;
    endcase
  end

  assign expired = elapsed > limit;

  // Step logic
  always_comb begin
    state_next       = state;
    last_stamp_next  = last_stamp;
    irq_latched_next = irq_latched;
    event_code       = bdlp_pkg::EV_NONE;
    if (item.action == bdlp_pkg::ACT_IRQ) begin
      if (cfg.interrupt_mode && (item.irq_pin_mask == cfg.button_pin_mask) &&
          (state == bdlp_pkg::ST_IDLE)) begin
        irq_latched_next = 1'b1;
      end
    end else begin
      case (state)
        bdlp_pkg::ST_IDLE: begin
          if (cfg.interrupt_mode ? irq_latched : item.pin_pressed) begin
            state_next      = bdlp_pkg::ST_DEBOUNCE;
            last_stamp_next = item.now_ms;
          end
        end
        bdlp_pkg::ST_DEBOUNCE: begin
          if (expired) begin
            if (cfg.interrupt_mode) irq_latched_next = 1'b0;
            if (item.pin_pressed) begin
              state_next      = bdlp_pkg::ST_PRESSED;
              last_stamp_next = item.now_ms;
              event_code      = bdlp_pkg::EV_PRESS;
            end else begin
              state_next = bdlp_pkg::ST_IDLE;
            end
          end
        end
        bdlp_pkg::ST_PRESSED, bdlp_pkg::ST_REPEAT: begin
          if (!item.pin_pressed) begin
            irq_latched_next = 1'b0;
            state_next = cfg.release_step_enable ? bdlp_pkg::ST_RELEASE
                                                 : bdlp_pkg::ST_IDLE;
          end else if (expired) begin
            state_next      = bdlp_pkg::ST_REPEAT;
            last_stamp_next = item.now_ms;
            event_code      = (state == bdlp_pkg::ST_PRESSED) ? bdlp_pkg::EV_LONG
                                                              : bdlp_pkg::EV_REPEAT;
          end
        end
        bdlp_pkg::ST_RELEASE: begin
          state_next = bdlp_pkg::ST_IDLE;
          event_code = bdlp_pkg::EV_RELEASE;
        end
        default: ;
      endcase
    end
  end

  assign state_out = bdlp_pkg::state_code(state_next);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bdlp_pkg::ST_IDLE;
      last_stamp  <= '0;
      irq_latched <= 1'b0;
    end else if (fire) begin
      state       <= state_next;
      last_stamp  <= last_stamp_next;
      irq_latched <= irq_latched_next;
    end
  end

endmodule

[src/button_debounce_longpress_repeat.sv]
// ----------------------------------------------------------------------------
// button_debounce_longpress_repeat: push-button qualifier
// Debounce, long press and auto-repeat on a step stream; one result per item.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, with the state update
//   between them; the result is registered. Throughput: one item per cycle
//   while the result channel is not stalled, set by the single state update
//   between the two registers.
// Reset: synchronous; state returns to idle, time stamp and interrupt flag to
//   zero, registers to their defaults, both pipeline registers empty.
module button_debounce_longpress_repeat (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // step channel
  input  logic        step_valid,
  output logic        step_stall,
  input  logic        action,
  input  logic        pin_pressed,
  input  logic [15:0] irq_pin_mask,
  input  logic [31:0] now_ms,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  event_res,
  output logic [2:0]  fsm_state_out
);

  bdlp_pkg::cfg_t   cfg;
  bdlp_pkg::item_t  s1_item;
  bdlp_pkg::event_t ev_code;
  logic             s1_valid;
  logic             res_load, s1_adv, step_acc;
  logic [2:0]       st_code;
  logic [2:0]       res_event, res_state;

  bdlp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Flow control
  assign res_load   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && res_load;
  assign step_stall = s1_valid && !res_load;
  assign step_acc   = step_valid && !step_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_acc) begin
      s1_item.action       <= action;
      s1_item.pin_pressed  <= pin_pressed;
      s1_item.irq_pin_mask <= irq_pin_mask;
      s1_item.now_ms       <= now_ms;
    end
  end

  bdlp_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (s1_adv),
    .item       (s1_item),
    .event_code (ev_code),
    .state_out  (st_code)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_event <= ev_code;
      res_state <= st_code;
    end
  end

  assign event_res     = res_event;
  assign fsm_state_out = res_state;

endmodule

[src/bdlp_checker.sv]
// ----------------------------------------------------------------------------
// bdlp_checker: port-level checks for the button qualifier
// Watches the result channel for hold behavior and event/state consistency.
// ----------------------------------------------------------------------------
module bdlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [2:0] event_res,
  input logic [2:0] fsm_state_out
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(event_res) &&
                                     $stable(fsm_state_out))
    else $error("result changed while stalled");

  // Press and long press land in the matching state
  a_press: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_res == bdlp_pkg::EV_PRESS) |->
      fsm_state_out == bdlp_pkg::SC_PRESSED)
    else $error("press event outside pressed state");

  a_long: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((event_res == bdlp_pkg::EV_LONG) ||
                     (event_res == bdlp_pkg::EV_REPEAT)) |->
      fsm_state_out == bdlp_pkg::SC_REPEAT)
    else $error("long press or repeat event outside repeat state");

  // Release event always returns to idle
  a_release: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_res == bdlp_pkg::EV_RELEASE) |->
      fsm_state_out == bdlp_pkg::SC_IDLE)
    else $error("release event not followed by idle");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind button_debounce_longpress_repeat bdlp_checker u_bdlp_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .event_res     (event_res),
  .fsm_state_out (fsm_state_out)
);
